// ===== sv/aip_pkg.sv =====
package aip_pkg;

	localparam int MAX_TOKEN_CHARS_DEF = 256;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_NUMBER_BASE   = 2'd0;
	localparam logic [1:0] REG_TARGET_BITS   = 2'd1;
	localparam logic [1:0] REG_TARGET_SIGNED = 2'd2;

	localparam logic [5:0] NUMBER_BASE_RST   = 6'd0;
	localparam logic [6:0] TARGET_BITS_RST   = 7'd32;
	localparam logic       TARGET_SIGNED_RST = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_OVER    = 3'd2;
	localparam logic [2:0] ST_UNDER   = 3'd3;
	localparam logic [2:0] ST_SIGNU   = 3'd4;

	localparam logic [1:0] WC_16 = 2'd0;
	localparam logic [1:0] WC_32 = 2'd1;
	localparam logic [1:0] WC_64 = 2'd2;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	localparam logic [5:0] BASE_HEX = 6'd16;
	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_DEC = 6'd10;
	localparam logic [5:0] BASE_MAX = 6'd36;
	localparam logic [5:0] NO_DIGIT = 6'd63;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic [63:0] parsed_value;
		logic [2:0]  parse_status;
		logic [8:0]  chars_consumed;
	} result_item_t;

	typedef struct packed {
		logic [5:0] number_base;
		logic [6:0] target_bits;
		logic       target_signed;
	} cfg_t;

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [5:0] d;
		d = NO_DIGIT;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = 6'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = 6'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			d = 6'(c - 8'h37);
		end
		return d;
	endfunction

	function automatic logic [5:0] base_or(input logic [5:0] nb, input logic [5:0] dflt);
		logic [5:0] b;
		if (nb == 6'd0) begin
			b = dflt;
		end else if (nb > BASE_MAX) begin
			b = BASE_MAX;
		end else begin
			b = nb;
		end
		return b;
	endfunction

	function automatic logic [1:0] width_code(input logic [6:0] tb);
		logic [1:0] w;
		if (tb == 7'd16) begin
			w = WC_16;
		end else if (tb == 7'd32) begin
			w = WC_32;
		end else begin
			w = WC_64;
		end
		return w;
	endfunction

	// largest magnitude the target can hold for the current sign
	function automatic logic [63:0] limit_of(input logic [1:0] wc, input logic sgn,
			input logic neg);
		logic [63:0] lim;
		case (wc)
			WC_16:   lim = sgn ? (neg ? 64'h8000 : 64'h7FFF) : 64'hFFFF;
			WC_32:   lim = sgn ? (neg ? 64'h8000_0000 : 64'h7FFF_FFFF) : 64'hFFFF_FFFF;
			default: lim = sgn ? (neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
				: 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return lim;
	endfunction

endpackage

// ===== sv/ascii_integer_parser_core.sv =====
// Character-serial integer parser. One character enters per item; the run of
// characters up to the item marked last_char holds one number, with an
// optional sign and, under base 0, a 0x (hex) or 0 (octal) prefix (0x also
// under base 16). When the parse stops, one result item carries the value
// (sign- or zero-extended to 64 bits), a status code and the count of
// characters consumed; characters after that up to last_char give no result.
// A new character is accepted every cycle unless the result side stalls.
// A character passes an input register, a parsing stage (a 64x6 multiply-add
// with a bound check against the target width), a sign and width finishing
// stage, and the result register. The user must write the registers through
// the APB port only while no item is in flight; the block does not enforce it.
module ascii_integer_parser_core #(
	parameter int MAX_TOKEN_CHARS = aip_pkg::MAX_TOKEN_CHARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_ready,
	input  aip_pkg::char_item_t           char_data,
	output logic                          result_valid,
	input  logic                          result_ready,
	output aip_pkg::result_item_t         result_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aip_pkg::ADDR_W-1:0]    paddr,
	input  logic [aip_pkg::DATA_W-1:0]    pwdata,
	output logic [aip_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int CNT_BITS = $clog2(MAX_TOKEN_CHARS + 1);
	localparam int CW       = (CNT_BITS > 9) ? CNT_BITS : 9;
	localparam logic [CW:0] CNT_MAX = (CW + 1)'(MAX_TOKEN_CHARS);

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SIGN   = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_X      = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	aip_pkg::cfg_t cfg;

	assign pready = 1'b1;

	aip_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// handshake chain
	logic                res_valid_q;
	aip_pkg::result_item_t res_q;
	logic                valid_s1;
	aip_pkg::char_item_t item_s1;
	logic                valid_s2;
	logic [63:0]         acc_s2;
	logic                neg_s2;
	logic [2:0]          st_s2;
	logic [8:0]          cnt_s2;
	logic [1:0]          wc_s2;
	logic                sgn_s2;

	logic out_load;
	logic s2_ready;
	logic s1_fire;

	assign out_load   = !res_valid_q || result_ready;
	assign s2_ready   = !valid_s2 || out_load;
	assign s1_fire    = valid_s1 && s2_ready;
	assign char_ready = !valid_s1 || s2_ready;

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_data;
		end
	end

	// token state
	logic [2:0]    phase_q;
	logic [63:0]   acc_q;
	logic          neg_q;
	logic [5:0]    base_q;
	logic [CW-1:0] cnt_q;
	logic          fin_q;

	logic [2:0]    phase_n;
	logic [63:0]   acc_n;
	logic          neg_n;
	logic [5:0]    base_n;
	logic [CW-1:0] cnt_n;
	logic          fin_n;

	logic          emit;
	logic [2:0]    st;
	logic [63:0]   rv;
	logic [CW-1:0] rc;

	logic [7:0]    c;
	logic          last;
	logic [5:0]    d;
	logic [1:0]    wc;
	logic [63:0]   lim;
	logic [5:0]    mul_b;
	logic [63:0]   mul_a;
	logic [70:0]   mac;
	logic          fits;
	logic [CW-1:0] cnt_inc1;
	logic [CW-1:0] cnt_inc2;
	logic [CW:0]   sum1;
	logic [CW:0]   sum2;

	assign c    = item_s1.char_code;
	assign last = item_s1.last_char;
	assign d    = aip_pkg::digit_of(c);
	assign wc   = aip_pkg::width_code(cfg.target_bits);
	assign lim  = aip_pkg::limit_of(wc, cfg.target_signed, neg_q);

	assign sum1     = {1'b0, cnt_q} + (CW + 1)'(1);
	assign sum2     = {1'b0, cnt_q} + (CW + 1)'(2);
	assign cnt_inc1 = (sum1 > CNT_MAX) ? CNT_MAX[CW-1:0] : sum1[CW-1:0];
	assign cnt_inc2 = (sum2 > CNT_MAX) ? CNT_MAX[CW-1:0] : sum2[CW-1:0];

	always_comb begin
		unique case (phase_q)
			PH_START, PH_SIGN: begin
				mul_b = aip_pkg::base_or(cfg.number_base, aip_pkg::BASE_DEC);
				mul_a = acc_q;
			end
			PH_ZERO: begin
				mul_b = aip_pkg::base_or(cfg.number_base, aip_pkg::BASE_OCT);
				mul_a = '0;
			end
			default: begin
				mul_b = (base_q == 6'd0) ? 6'd1 : base_q;
				mul_a = acc_q;
			end
		endcase
	end

	assign mac  = {7'd0, mul_a} * {65'd0, mul_b} + {65'd0, d};
	assign fits = mac <= {7'd0, lim};

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		base_n  = base_q;
		cnt_n   = cnt_q;
		fin_n   = fin_q;
		emit    = 1'b0;
		st      = aip_pkg::ST_OK;
		rv      = '0;
		rc      = '0;

		if (!fin_q) begin
			unique case (phase_q)
				PH_START, PH_SIGN: begin
					if (phase_q == PH_START && c == aip_pkg::CH_MINUS && !cfg.target_signed) begin
						emit = 1'b1;
						st   = aip_pkg::ST_SIGNU;
					end else if (phase_q == PH_START
							&& (c == aip_pkg::CH_MINUS || c == aip_pkg::CH_PLUS)) begin
						neg_n   = (c == aip_pkg::CH_MINUS);
						cnt_n   = CW'(1);
						phase_n = PH_SIGN;
						if (last) begin
							emit = 1'b1;
							st   = aip_pkg::ST_INVALID;
						end
					end else if (c == aip_pkg::CH_ZERO) begin
						cnt_n   = cnt_inc1;
						phase_n = PH_ZERO;
						if (last) begin
							emit = 1'b1;
							rc   = cnt_inc1;
						end
					end else begin
						base_n = mul_b;
						if (d < mul_b && fits) begin
							acc_n   = mac[63:0];
							cnt_n   = cnt_inc1;
							phase_n = PH_DIGITS;
							if (last) begin
								emit = 1'b1;
								rv   = mac[63:0];
								rc   = cnt_inc1;
							end
						end else begin
							emit = 1'b1;
							st   = aip_pkg::ST_INVALID;
						end
					end
				end
				PH_ZERO: begin
					if (c == aip_pkg::CH_X_LO || c == aip_pkg::CH_X_UP) begin
						if (cfg.number_base != 6'd0 && cfg.number_base != aip_pkg::BASE_HEX) begin
							emit = 1'b1;
							rc   = cnt_q;
						end else begin
							base_n  = aip_pkg::BASE_HEX;
							phase_n = PH_X;
							if (last) begin
								emit = 1'b1;
								rc   = cnt_q;
							end
						end
					end else begin
						base_n = mul_b;
						acc_n  = '0;
						if (d < mul_b && fits) begin
							acc_n   = mac[63:0];
							cnt_n   = cnt_inc1;
							phase_n = PH_DIGITS;
							if (last) begin
								emit = 1'b1;
								rv   = mac[63:0];
								rc   = cnt_inc1;
							end
						end else begin
							emit = 1'b1;
							rc   = cnt_q;
						end
					end
				end
				PH_X: begin
					acc_n = '0;
					if (d < aip_pkg::BASE_HEX) begin
						acc_n   = {58'd0, d};
						cnt_n   = cnt_inc2;
						phase_n = PH_DIGITS;
						if (last) begin
							emit = 1'b1;
							rv   = {58'd0, d};
							rc   = cnt_inc2;
						end
					end else begin
						emit = 1'b1;
						rc   = cnt_q;
					end
				end
				default: begin
					if (d < base_q) begin
						if (!fits) begin
							emit = 1'b1;
							st   = neg_q ? aip_pkg::ST_UNDER : aip_pkg::ST_OVER;
						end else begin
							acc_n = mac[63:0];
							cnt_n = cnt_inc1;
							if (last) begin
								emit = 1'b1;
								rv   = mac[63:0];
								rc   = cnt_inc1;
							end
						end
					end else begin
						emit = 1'b1;
						rv   = acc_q;
						rc   = cnt_q;
					end
				end
			endcase
		end

		if (last) begin
			phase_n = PH_START;
			acc_n   = '0;
			neg_n   = 1'b0;
			base_n  = '0;
			cnt_n   = '0;
			fin_n   = 1'b0;
		end else if (emit) begin
			fin_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
		end else if (s1_fire) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			base_q  <= base_n;
			cnt_q   <= cnt_n;
			fin_q   <= fin_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= s1_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			acc_s2 <= rv;
			neg_s2 <= neg_q;
			st_s2  <= st;
			cnt_s2 <= rc[8:0];
			wc_s2  <= wc;
			sgn_s2 <= cfg.target_signed;
		end
	end

	// sign and width finishing
	logic [63:0] mag;
	logic [63:0] fin_val;

	assign mag = neg_s2 ? (64'd0 - acc_s2) : acc_s2;

	always_comb begin
		case (wc_s2)
			aip_pkg::WC_16: fin_val = {{48{sgn_s2 & mag[15]}}, mag[15:0]};
			aip_pkg::WC_32: fin_val = {{32{sgn_s2 & mag[31]}}, mag[31:0]};
			default:        fin_val = mag;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			res_q.parsed_value   <= fin_val;
			res_q.parse_status   <= st_s2;
			res_q.chars_consumed <= cnt_s2;
		end
	end

endmodule

// ===== sv/aip_cfg.sv =====
module aip_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aip_pkg::ADDR_W-1:0]    paddr,
	input  logic [aip_pkg::DATA_W-1:0]    pwdata,
	output logic [aip_pkg::DATA_W-1:0]    prdata,
	output aip_pkg::cfg_t                 cfg
);

	aip_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.number_base   <= aip_pkg::NUMBER_BASE_RST;
			cfg_q.target_bits   <= aip_pkg::TARGET_BITS_RST;
			cfg_q.target_signed <= aip_pkg::TARGET_SIGNED_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				aip_pkg::REG_NUMBER_BASE:   cfg_q.number_base   <= pwdata[5:0];
				aip_pkg::REG_TARGET_BITS:   cfg_q.target_bits   <= pwdata[6:0];
				aip_pkg::REG_TARGET_SIGNED: cfg_q.target_signed <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			aip_pkg::REG_NUMBER_BASE:   prdata = {26'd0, cfg_q.number_base};
			aip_pkg::REG_TARGET_BITS:   prdata = {25'd0, cfg_q.target_bits};
			aip_pkg::REG_TARGET_SIGNED: prdata = {31'd0, cfg_q.target_signed};
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== test/ascii_integer_parser_core_test.sv =====
module ascii_integer_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {AT_START, AFTER_SIGN, AFTER_ZERO, AFTER_X, IN_DIGITS} scan_phase_e;

	logic                          clk;
	logic                          arst_n;
	logic                          char_valid;
	logic                          char_ready;
	aip_pkg::char_item_t           char_data;
	logic                          result_valid;
	logic                          result_ready;
	aip_pkg::result_item_t         result_data;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [aip_pkg::ADDR_W-1:0]    paddr;
	logic [aip_pkg::DATA_W-1:0]    pwdata;
	logic [aip_pkg::DATA_W-1:0]    prdata;
	logic                          pready;

	// register shadow
	logic [5:0]          cfg_base = aip_pkg::NUMBER_BASE_RST;
	logic [6:0]          cfg_bits = aip_pkg::TARGET_BITS_RST;
	logic                cfg_signed = aip_pkg::TARGET_SIGNED_RST;

	// token state of the predictor
	scan_phase_e         tok_phase = AT_START;
	logic [63:0]         tok_acc = '0;
	logic                tok_neg = 1'b0;
	logic [5:0]          tok_base = '0;
	logic [8:0]          tok_count = '0;
	logic                tok_done = 1'b0;

	aip_pkg::result_item_t results_due[$];
	int unsigned         chars_sent = 0;
	int unsigned         fail_count = 0;
	int unsigned         hold_request = 0;
	bit                  steady = 0;

	ascii_integer_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data(char_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int unsigned target_width();
		if (cfg_bits == 7'd16) return 16;
		if (cfg_bits == 7'd32) return 32;
		return 64;
	endfunction

	function automatic logic [5:0] char_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 6'(c - aip_pkg::CH_ZERO);
		if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd10);
		if (c >= "A" && c <= "Z") return 6'(c - "A" + 8'd10);
		return aip_pkg::NO_DIGIT;
	endfunction

	function automatic logic [5:0] radix_or(input logic [5:0] dflt);
		if (cfg_base == 6'd0) return dflt;
		if (cfg_base > aip_pkg::BASE_MAX) return aip_pkg::BASE_MAX;
		return cfg_base;
	endfunction

	function automatic logic [8:0] count_up(input int unsigned k);
		int unsigned s;
		s = tok_count + k;
		return (s > aip_pkg::MAX_TOKEN_CHARS_DEF) ? 9'(aip_pkg::MAX_TOKEN_CHARS_DEF) : 9'(s);
	endfunction

	function automatic void clear_token();
		tok_phase = AT_START;
		tok_acc = '0;
		tok_neg = 1'b0;
		tok_base = '0;
		tok_count = '0;
		tok_done = 1'b0;
	endfunction

	function automatic aip_pkg::result_item_t fail_item(input logic [2:0] st);
		aip_pkg::result_item_t r;
		r.parsed_value = '0;
		r.parse_status = st;
		r.chars_consumed = '0;
		return r;
	endfunction

	function automatic aip_pkg::result_item_t ok_item();
		aip_pkg::result_item_t r;
		int unsigned w;
		logic [63:0] m, v;
		w = target_width();
		m = (w == 64) ? ~64'd0 : ((64'd1 << w) - 64'd1);
		v = (tok_neg ? (64'd0 - tok_acc) : tok_acc) & m;
		if (cfg_signed && w < 64 && v[w - 1]) v = v | ~m;
		r.parsed_value = v;
		r.parse_status = aip_pkg::ST_OK;
		r.chars_consumed = tok_count;
		return r;
	endfunction

	// multiply-add with range check; leaves the accumulator alone on overflow
	function automatic bit add_digit(input logic [5:0] d);
		logic [63:0] bound, radix;
		int unsigned w;
		w = target_width();
		if (cfg_signed) bound = (64'd1 << (w - 1)) - (tok_neg ? 64'd0 : 64'd1);
		else bound = (w == 64) ? ~64'd0 : ((64'd1 << w) - 64'd1);
		radix = (tok_base != 6'd0) ? 64'(tok_base) : 64'd1;
		if (tok_acc > bound / radix || (tok_acc == bound / radix && 64'(d) > bound % radix))
			return 1'b0;
		tok_acc = tok_acc * radix + 64'(d);
		return 1'b1;
	endfunction

	function automatic void scan_char(input logic [7:0] c, input bit last);
		aip_pkg::result_item_t r;
		bit emit;
		logic [5:0] d;
		emit = 0;
		r = '0;
		if (tok_done) begin
			if (last) clear_token();
			return;
		end
		d = char_digit(c);
		case (tok_phase)
			AT_START, AFTER_SIGN: begin
				if (tok_phase == AT_START && c == aip_pkg::CH_MINUS && !cfg_signed) begin
					r = fail_item(aip_pkg::ST_SIGNU);
					emit = 1;
				end else if (tok_phase == AT_START
						&& (c == aip_pkg::CH_MINUS || c == aip_pkg::CH_PLUS)) begin
					tok_neg = (c == aip_pkg::CH_MINUS);
					tok_count = 9'd1;
					tok_phase = AFTER_SIGN;
					if (last) begin
						r = fail_item(aip_pkg::ST_INVALID);
						emit = 1;
					end
				end else if (c == aip_pkg::CH_ZERO) begin
					tok_count = count_up(1);
					tok_phase = AFTER_ZERO;
					if (last) begin
						tok_acc = '0;
						r = ok_item();
						emit = 1;
					end
				end else begin
					tok_base = radix_or(aip_pkg::BASE_DEC);
					emit = 1;
					r = fail_item(aip_pkg::ST_INVALID);
					if (d < tok_base) begin
						if (add_digit(d)) begin
							emit = 0;
							tok_count = count_up(1);
							tok_phase = IN_DIGITS;
							if (last) begin
								r = ok_item();
								emit = 1;
							end
						end
					end
				end
			end
			AFTER_ZERO: begin
				if (c == aip_pkg::CH_X_LO || c == aip_pkg::CH_X_UP) begin
					if (cfg_base != 6'd0 && cfg_base != aip_pkg::BASE_HEX) begin
						tok_acc = '0;
						r = ok_item();
						emit = 1;
					end else begin
						tok_base = aip_pkg::BASE_HEX;
						tok_phase = AFTER_X;
						if (last) begin
							tok_acc = '0;
							r = ok_item();
							emit = 1;
						end
					end
				end else begin
					tok_base = radix_or(aip_pkg::BASE_OCT);
					tok_acc = '0;
					emit = 1;
					if (d < tok_base) begin
						if (add_digit(d)) begin
							emit = 0;
							tok_count = count_up(1);
							tok_phase = IN_DIGITS;
							if (last) emit = 1;
						end
					end
					if (emit) r = ok_item();
				end
			end
			AFTER_X: begin
				tok_acc = '0;
				if (d < aip_pkg::BASE_HEX) begin
					tok_acc = 64'(d);
					tok_count = count_up(2);
					tok_phase = IN_DIGITS;
					if (last) begin
						r = ok_item();
						emit = 1;
					end
				end else begin
					r = ok_item();
					emit = 1;
				end
			end
			default: begin
				if (d < tok_base) begin
					if (!add_digit(d)) begin
						r = fail_item(tok_neg ? aip_pkg::ST_UNDER : aip_pkg::ST_OVER);
						emit = 1;
					end else begin
						tok_count = count_up(1);
						if (last) begin
							r = ok_item();
							emit = 1;
						end
					end
				end else begin
					r = ok_item();
					emit = 1;
				end
			end
		endcase
		if (emit) results_due.push_back(r);
		if (last) clear_token();
		else if (emit) tok_done = 1'b1;
	endfunction

	// result checker
	always @(posedge clk) begin
		aip_pkg::result_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (results_due.size() == 0) begin
				$error("unexpected result item: %h", result_data);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (result_data.parsed_value !== want.parsed_value) begin
					$error("parsed_value: expected %h, got %h", want.parsed_value,
						result_data.parsed_value);
					fail_count++;
				end
				if (result_data.parse_status !== want.parse_status) begin
					$error("parse_status: expected %0d, got %0d", want.parse_status,
						result_data.parse_status);
					fail_count++;
				end
				if (result_data.chars_consumed !== want.chars_consumed) begin
					$error("chars_consumed: expected %0d, got %0d", want.chars_consumed,
						result_data.chars_consumed);
					fail_count++;
				end
			end
		end
	end

	// result side: random stalls, plus long holds on request
	initial begin
		int unsigned held;
		held = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				held = hold_request;
				hold_request = 0;
			end
			if (held != 0) begin
				result_ready <= 1'b0;
				held--;
			end else begin
				result_ready <= steady || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic push_char(input logic [7:0] c, input bit last);
		while (!steady && $urandom_range(0, 99) < 16) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_data <= '{char_code: c, last_char: last};
		do @(posedge clk); while (!char_ready);
		scan_char(c, last);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
	endtask

	task automatic wait_idle();
		char_valid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			aip_pkg::REG_NUMBER_BASE: cfg_base = value[5:0];
			aip_pkg::REG_TARGET_BITS: cfg_bits = value[6:0];
			aip_pkg::REG_TARGET_SIGNED: cfg_signed = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [5:0] base, input logic [6:0] bits, input logic sgn);
		wait_idle();
		write_reg(aip_pkg::REG_NUMBER_BASE, 32'(base));
		write_reg(aip_pkg::REG_TARGET_BITS, 32'(bits));
		write_reg(aip_pkg::REG_TARGET_SIGNED, 32'(sgn));
	endtask

	function automatic logic [7:0] digit_char(input int unsigned v);
		if (v < 10) return 8'(aip_pkg::CH_ZERO + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 9))
			0: return aip_pkg::CH_MINUS;
			1: return aip_pkg::CH_PLUS;
			2: return aip_pkg::CH_ZERO;
			3: return aip_pkg::CH_X_LO;
			4: return aip_pkg::CH_X_UP;
			5: return " ";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly well-formed numbers for the current base, some near the bound,
	// some broken or pure noise
	task automatic send_random_number();
		logic [7:0] text[$];
		logic [64:0] mag, lim;
		int unsigned w, eb, n;
		bit neg;
		w = target_width();
		eb = radix_or(aip_pkg::BASE_DEC);
		neg = 0;
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 4)) text.push_back(noise_char());
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					text.push_back(aip_pkg::CH_MINUS);
					neg = 1;
				end
				1: text.push_back(aip_pkg::CH_PLUS);
				default: ;
			endcase
			if (cfg_base == 6'd0) begin
				case ($urandom_range(0, 2))
					1: begin
						text.push_back(aip_pkg::CH_ZERO);
						text.push_back($urandom_range(0, 1) ? aip_pkg::CH_X_LO : aip_pkg::CH_X_UP);
						eb = aip_pkg::BASE_HEX;
					end
					2: begin
						text.push_back(aip_pkg::CH_ZERO);
						eb = aip_pkg::BASE_OCT;
					end
					default: ;
				endcase
			end else if ((eb == aip_pkg::BASE_HEX && $urandom_range(0, 3) == 0) ||
					$urandom_range(0, 19) == 0) begin
				text.push_back(aip_pkg::CH_ZERO);
				text.push_back(aip_pkg::CH_X_LO);
			end
			if (cfg_signed) lim = (65'd1 << (w - 1)) - (neg ? 65'd0 : 65'd1);
			else lim = (65'd1 << w) - 65'd1;
			case ($urandom_range(0, 2))
				0: mag = 65'($urandom_range(0, 999));
				1: mag = lim - 65'd2 + 65'($urandom_range(0, 4));
				default: mag = 65'({$urandom, $urandom, $urandom}) >> $urandom_range(0, 64);
			endcase
			if (eb == 1) begin
				repeat ($urandom_range(1, 4)) text.push_back(aip_pkg::CH_ZERO);
			end else begin
				n = text.size();
				do begin
					text.insert(n, digit_char(32'(mag % 65'(eb))));
					mag = mag / 65'(eb);
				end while (mag != 0);
			end
			if ($urandom_range(0, 9) == 0)
				text.insert($urandom_range(0, text.size()), noise_char());
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 3))
					text.push_back($urandom_range(0, 1) ? noise_char() :
						digit_char($urandom_range(0, 9)));
		end
		foreach (text[i]) push_char(text[i], i == text.size() - 1);
	endtask

	task automatic check_reset_config();
		send_text("-12");
		send_text("+7");
		send_text("0x1F");
		send_text("017");
		send_text("z");
		push_char(8'hFF, 1'b1);
		push_char(8'h00, 1'b1);
	endtask

	task automatic check_special_cases();
		set_config(6'd0, 7'd32, 1'b1);
		send_text("0x");
		send_text("0xg9");
		send_text("-");
		send_text("+x");
		send_text("08");
		send_text("0X7f");
		set_config(aip_pkg::BASE_DEC, 7'd32, 1'b1);
		send_text("0x5");
		set_config(6'd1, 7'd32, 1'b1);
		send_text("001");
		set_config(6'd63, 7'd0, 1'b1);
		send_text("zZ");
		send_text("-5");
		set_config(6'd0, 7'd127, 1'b0);
		send_text("-3");
	endtask

	task automatic check_bounds();
		set_config(aip_pkg::BASE_DEC, 7'd16, 1'b1);
		send_text("32767");
		send_text("-32768");
		send_text("32768");
		send_text("-32769");
		set_config(6'd0, 7'd16, 1'b0);
		send_text("65535");
		send_text("65536");
	endtask

	task automatic check_live_writes();
		set_config(6'd0, 7'd32, 1'b1);
		push_char(aip_pkg::CH_ZERO, 1'b0);
		wait_idle();
		write_reg(aip_pkg::REG_NUMBER_BASE, 32'(aip_pkg::BASE_DEC));
		push_char(aip_pkg::CH_X_LO, 1'b1);
		set_config(6'd0, 7'd64, 1'b1);
		push_char("7", 1'b0);
		repeat (4) push_char(aip_pkg::CH_ZERO, 1'b0);
		wait_idle();
		write_reg(aip_pkg::REG_TARGET_BITS, 32'd16);
		push_char(aip_pkg::CH_ZERO, 1'b1);
	endtask

	task automatic check_long_token();
		set_config(aip_pkg::BASE_DEC, 7'd64, 1'b0);
		repeat (259) push_char(aip_pkg::CH_ZERO, 1'b0);
		push_char(aip_pkg::CH_ZERO, 1'b1);
	endtask

	task automatic check_backpressure();
		set_config(6'd0, 7'd32, 1'b1);
		hold_request = 300;
		repeat (60) push_char(digit_char($urandom_range(0, 9)), 1'b1);
		wait_idle();
	endtask

	task automatic check_random_text();
		int unsigned stop_at, phase_end, phase_no;
		logic [5:0] base;
		logic [6:0] bits;
		stop_at = chars_sent + 440;
		phase_no = 0;
		while (chars_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: base = 6'd0;
				4: base = aip_pkg::BASE_DEC;
				5: base = aip_pkg::BASE_HEX;
				6: base = aip_pkg::BASE_OCT;
				7: base = 6'd2;
				8: base = aip_pkg::BASE_MAX;
				default: base = 6'($urandom_range(0, 63));
			endcase
			case ($urandom_range(0, 4))
				0: bits = 7'd16;
				1: bits = 7'd32;
				2, 3: bits = 7'd64;
				default: bits = 7'($urandom_range(0, 127));
			endcase
			set_config(base, bits, 1'($urandom_range(0, 1)));
			steady = (phase_no == 2);
			phase_end = chars_sent + (steady ? 150 : 60);
			while (chars_sent < phase_end) send_random_number();
			phase_no++;
		end
		steady = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_reset_config();
		check_special_cases();
		check_bounds();
		check_live_writes();
		check_long_token();
		check_backpressure();
		check_random_text();
		wait_idle();
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
